// ===== hdl/abc_pkg.sv =====
// Package with the types, constants and curve tables of the brightness channel.
package abc_pkg;

   localparam int LUX_W   = 20;
   localparam int LEVEL_W = 16;
   localparam int PCT_W   = 7;
   localparam int RPCT_W  = 10;
   localparam int TABLE_MAX = 16;
   localparam int CNT_W   = 6;

   localparam logic [2:0] REG_CURVE  = 3'd0;
   localparam logic [2:0] REG_MAX    = 3'd1;
   localparam logic [2:0] REG_FLOOR  = 3'd2;
   localparam logic [2:0] REG_RPCT   = 3'd3;
   localparam logic [2:0] REG_RABS   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVED,
      ST_CURVE,
      ST_SCALE,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [LUX_W+7-1:0]  dividend;
      logic [LUX_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [LUX_W+7-1:0]  quotient;
   } div_rsp_type;

   function automatic logic [10:0] curve_x(input logic sel, input logic [3:0] i);
      logic [10:0] rx [TABLE_MAX];
      logic [10:0] fx [TABLE_MAX];
      rx = '{11'd0, 11'd1, 11'd5, 11'd20, 11'd50, 11'd100, 11'd200, 11'd400,
             11'd700, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
             11'd1000, 11'd1000};
      fx = '{11'd0, 11'd5, 11'd20, 11'd50, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
             11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
             11'd1000, 11'd1000};
      return sel ? fx[i] : rx[i];
   endfunction

   function automatic logic [6:0] curve_y(input logic sel, input logic [3:0] i);
      logic [6:0] ry [TABLE_MAX];
      logic [6:0] fy [TABLE_MAX];
      ry = '{7'd2, 7'd3, 7'd6, 7'd12, 7'd24, 7'd40, 7'd60, 7'd80, 7'd92, 7'd100,
             7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100};
      fy = '{7'd75, 7'd50, 7'd25, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
             7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
      return sel ? fy[i] : ry[i];
   endfunction

endpackage

// ===== hdl/abc_divider.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
module abc_divider (
   input  logic                clock,
   input  logic                reset,
   input  abc_pkg::div_req_type req,
   output abc_pkg::div_rsp_type rsp
);
   import abc_pkg::*;

   localparam int QW = LUX_W + 7;

   logic [QW-1:0]   quo_ff, quo_in;
   logic [LUX_W:0]  rem_ff, rem_in;
   logic [LUX_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [LUX_W+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QW-1]} - {2'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CNT_W'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[LUX_W+1]) begin
            rem_in = trial[LUX_W:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[LUX_W-1:0], quo_ff[QW-1]};
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_done_busy: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !$past(req.start)) |-> !busy_ff) else $error("divider busy at done");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CNT_W'(QW))) else $error("divider count out of range");
`endif
endmodule

// ===== hdl/ambient_brightness_channel_top.sv =====
// Top level of the ambient brightness channel with control and config registers.
//  channel | direction | fields (low bit up)
//  req     | in        | tdata: lux, observed_level, observed_valid, boost
//  rsp     | out       | tdata: write_en, write_level, override_on, target_level
//  csr     | in/out    | APB registers at 4*i
// A failed read answers in the cycle after the request is taken; a held override passes ST_MOVED and ST_FINISH.
// Each division loads its operands, shifts out 27 quotient bits and then raises done.
// A curve end needs no interpolation division; an interpolated point first steps to its segment, then divides.
// An override that ends on the lux ratio adds the division for that ratio.
// Reset restores the control state and config registers, not the data registers. A result waits in rsp until taken,
// and the next request is accepted only after the result leaves.
module ambient_brightness_channel_top #(
   parameter int CURVE_POINTS = 10,
   parameter int SMOOTH_BITS  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // lux, observed_level, observed_valid, boost
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // write_en, write_level, override_on, target_level
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import abc_pkg::*;

   localparam int NPTS = (CURVE_POINTS > TABLE_MAX) ? TABLE_MAX :
                         (CURVE_POINTS < 2) ? 2 : CURVE_POINTS;
   localparam logic [3:0] LAST = 4'(NPTS - 1);

   logic             curve_ff;
   logic [15:0]      max_ff;
   logic [6:0]       floor_ff;
   logic [9:0]       rpct_ff;
   logic [15:0]      rabs_ff;
   logic             wr;
   logic [2:0]       ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= 1'b0;
         max_ff   <= 16'd255;
         floor_ff <= 7'd2;
         rpct_ff  <= 10'd75;
         rabs_ff  <= 16'd5;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (ridx)
            REG_CURVE: curve_ff <= csr_pwdata[0];
            REG_MAX:   max_ff   <= csr_pwdata[15:0];
            REG_FLOOR: floor_ff <= csr_pwdata[6:0];
            REG_RPCT:  rpct_ff  <= csr_pwdata[9:0];
            REG_RABS:  rabs_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (ridx)
            REG_CURVE: csr_prdata = {31'd0, curve_ff};
            REG_MAX:   csr_prdata = {16'd0, max_ff};
            REG_FLOOR: csr_prdata = {25'd0, floor_ff};
            REG_RPCT:  csr_prdata = {22'd0, rpct_ff};
            REG_RABS:  csr_prdata = {16'd0, rabs_ff};
            default:   csr_prdata = '0;
         endcase
      end
   end

   state_type   state_ff, state_in;
   logic [19:0] lux_ff, lux_in;
   logic [15:0] obs_ff, obs_in;
   logic [6:0]  boost_ff, boost_in;
   logic [15:0] last_ff, last_in;
   logic        lvalid_ff, lvalid_in;
   logic        ovr_ff, ovr_in;
   logic [19:0] base_ff, base_in;
   logic [3:0]  idx_ff, idx_in;
   logic [6:0]  pct_ff, pct_in;
   logic        rv_ff, rv_in;
   logic [39:0] rd_ff, rd_in;
   div_req_type dreq;
   div_rsp_type drsp;

   abc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [19:0] d;
   logic [10:0] x0, x1;
   logic [6:0]  y0, y1;
   logic [7:0]  ysum;
   logic [7:0]  pclamp;
   logic [15:0] tgt, mag, stepv, nxt;
   logic [26:0] q;

   assign q = drsp.quotient;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      state_in = state_ff;
      lux_in = lux_ff; obs_in = obs_ff; boost_in = boost_ff;
      last_in = last_ff; lvalid_in = lvalid_ff; ovr_in = ovr_ff; base_in = base_ff;
      idx_in = idx_ff; pct_in = pct_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      dreq = '{start: 1'b0, dividend: '0, divisor: '0};
      d = (lux_ff > base_ff) ? lux_ff - base_ff : base_ff - lux_ff;
      x0 = curve_x(curve_ff, idx_ff - 4'd1);
      x1 = curve_x(curve_ff, idx_ff);
      y0 = curve_y(curve_ff, idx_ff - 4'd1);
      y1 = curve_y(curve_ff, idx_ff);
      ysum = 8'(pct_ff) + 8'(boost_ff);
      pclamp = ysum;
      if (pclamp < 8'(floor_ff)) pclamp = 8'(floor_ff);
      if (pclamp > 8'd100) pclamp = 8'd100;
      tgt = q[15:0];
      mag = '0; stepv = '0; nxt = obs_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               lux_in = req_tdata[19:0];
               obs_in = req_tdata[35:20];
               boost_in = req_tdata[43:37];
               if (!req_tdata[36]) begin
                  rd_in = {22'd0, ovr_ff, 17'd0};
                  rv_in = 1'b1;
               end else begin
                  if (lvalid_ff && req_tdata[35:20] != last_ff) begin
                     ovr_in = 1'b1;
                     base_in = req_tdata[19:0];
                  end
                  state_in = ST_MOVED;
               end
            end
         end
         ST_MOVED: begin
            if (drsp.done) begin
               if (q >= 27'(rpct_ff)) ovr_in = 1'b0;
               state_in = ST_FINISH;
               idx_in = 4'd0;
            end else if (!drsp.busy) begin
               if (!ovr_ff) begin
                  idx_in = 4'd0;
                  state_in = ST_CURVE;
               end else if (d < 20'(rabs_ff)) begin
                  state_in = ST_FINISH;
               end else if (base_ff == '0) begin
                  ovr_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  dreq.start = 1'b1;
                  dreq.dividend = 27'(d) * 27'd100;
                  dreq.divisor = base_ff;
               end
            end
         end
         ST_FINISH: begin
            if (ovr_ff) begin
               last_in = obs_ff; lvalid_in = 1'b1;
               rd_in = {22'd0, 1'b1, 17'd0};
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = 4'd0;
               state_in = ST_CURVE;
            end
         end
         ST_CURVE: begin
            if (drsp.done) begin
               if (y1 >= y0) pct_in = 7'(8'(y0) + q[7:0]);
               else pct_in = 7'(8'(y0) - q[7:0]);
               state_in = ST_SCALE;
               idx_in = 4'd0;
            end else if (!drsp.busy) begin
               if (idx_ff == 4'd0) begin
                  if (lux_ff <= 20'(curve_x(curve_ff, 4'd0))) begin
                     pct_in = curve_y(curve_ff, 4'd0);
                     state_in = ST_SCALE;
                  end else if (lux_ff >= 20'(curve_x(curve_ff, LAST))) begin
                     pct_in = curve_y(curve_ff, LAST);
                     state_in = ST_SCALE;
                  end else begin
                     idx_in = 4'd1;
                  end
               end else if (lux_ff <= 20'(x1)) begin
                  if (x1 <= x0) begin
                     pct_in = y1;
                     state_in = ST_SCALE;
                     idx_in = 4'd0;
                  end else if (y1 >= y0) begin
                     dreq.start = 1'b1;
                     dreq.dividend = 27'(y1 - y0) * 27'(lux_ff - 20'(x0));
                     dreq.divisor = 20'(x1 - x0);
                  end else begin
                     dreq.start = 1'b1;
                     dreq.dividend = 27'(y0 - y1) * 27'(lux_ff - 20'(x0));
                     dreq.divisor = 20'(x1 - x0);
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_SCALE: begin
            if (drsp.done) begin
               if (tgt > obs_ff) begin
                  mag = tgt - obs_ff;
                  stepv = mag >> SMOOTH_BITS;
                  if (stepv == '0) stepv = 16'd1;
                  nxt = obs_ff + stepv;
               end else if (tgt < obs_ff) begin
                  mag = obs_ff - tgt;
                  stepv = 16'((17'(mag) + 17'((1 << SMOOTH_BITS) - 1)) >> SMOOTH_BITS);
                  nxt = obs_ff - stepv;
               end
               last_in = nxt; lvalid_in = 1'b1;
               rd_in = 40'({tgt, 1'b0, (nxt != obs_ff) ? nxt : 16'd0, nxt != obs_ff});
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end else if (!drsp.busy) begin
               dreq.start = 1'b1;
               dreq.dividend = 27'(pclamp) * 27'(max_ff);
               dreq.divisor = 20'd100;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      lux_ff <= lux_in; obs_ff <= obs_in; boost_ff <= boost_in;
      idx_ff <= idx_in; pct_ff <= pct_in; rd_ff <= rd_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= '0; lvalid_ff <= 1'b0; ovr_ff <= 1'b0; base_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in; lvalid_ff <= lvalid_in; ovr_ff <= ovr_in;
         base_ff <= base_in; rv_ff <= rv_in;
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> rv_ff) else $error("result dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_tready) else $error("request taken while result waits");
   a_ovr_tgt: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rd_ff[17]) |-> (rd_ff[33:18] == '0 && !rd_ff[0]))
      else $error("override result carries a level");
`endif
endmodule

// ===== verif/tb_ambient_brightness_channel_top.sv =====
// Testbench for the ambient brightness channel: directed and random requests checked against a predictor.
module tb_ambient_brightness_channel_top;
   timeunit 1ns;
   timeprecision 1ps;

   import abc_pkg::*;

   typedef struct packed {
      logic [6:0]  boost;
      logic        observed_valid;
      logic [15:0] observed_level;
      logic [19:0] lux;
   } request_type;

   typedef struct packed {
      logic [15:0] target_level;
      logic        override_on;
      logic [15:0] write_level;
      logic        write_en;
   } result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ambient_brightness_channel_top u_top (.*);

   request_type pending_requests[$];
   result_type  expected_results[$];
   int          error_count;
   int          result_count;
   int          override_count;
   int          write_count;
   bit          calm;

   logic        sel_curve;
   logic [15:0] full_scale;
   logic [6:0]  floor_limit;
   logic [9:0]  resume_rel;
   logic [15:0] resume_min;
   logic [15:0] held_level;
   logic        held_valid;
   logic        yielding;
   logic [19:0] base_lux;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int curve_percent(input logic [19:0] lux);
      int xs[10];
      int ys[10];
      int lx;
      lx = lux;
      if (sel_curve) begin
         xs = '{0, 5, 20, 50, 1000, 1000, 1000, 1000, 1000, 1000};
         ys = '{75, 50, 25, 0, 0, 0, 0, 0, 0, 0};
      end else begin
         xs = '{0, 1, 5, 20, 50, 100, 200, 400, 700, 1000};
         ys = '{2, 3, 6, 12, 24, 40, 60, 80, 92, 100};
      end
      if (lx <= xs[0]) return ys[0];
      if (lx >= xs[9]) return ys[9];
      for (int i = 1; i < 10; i++) begin
         if (lx <= xs[i]) begin
            if (xs[i] - xs[i-1] <= 0) return ys[i];
            return ys[i-1] + (ys[i] - ys[i-1]) * (lx - xs[i-1]) / (xs[i] - xs[i-1]);
         end
      end
      return ys[9];
   endfunction

   function automatic bit lux_departed(input logic [19:0] lux);
      longint unsigned d;
      d = (lux > base_lux) ? lux - base_lux : base_lux - lux;
      if (d < resume_min) return 0;
      if (base_lux == 0) return 1;
      return (d * 100) / base_lux >= resume_rel;
   endfunction

   function automatic result_type next_brightness(input request_type r);
      result_type  res;
      int unsigned pct;
      int unsigned tgt;
      int unsigned nxt;
      int unsigned gap;
      res = '0;
      if (!r.observed_valid) begin
         res.override_on = yielding;
         return res;
      end
      if (held_valid && r.observed_level != held_level) begin
         yielding = 1;
         base_lux = r.lux;
      end
      if (yielding && lux_departed(r.lux)) yielding = 0;
      if (yielding) begin
         held_level = r.observed_level;
         held_valid = 1;
         res.override_on = 1;
         return res;
      end
      pct = curve_percent(r.lux) + r.boost;
      if (pct < floor_limit) pct = floor_limit;
      if (pct > 100) pct = 100;
      tgt = pct * full_scale / 100;
      nxt = r.observed_level;
      if (tgt > nxt) begin
         gap = (tgt - nxt) >> 4;
         nxt = nxt + ((gap < 1) ? 1 : gap);
      end else if (tgt < nxt) begin
         gap = (nxt - tgt + 15) >> 4;
         nxt = nxt - ((gap < 1) ? 1 : gap);
      end
      held_level = nxt[15:0];
      held_valid = 1;
      if (nxt[15:0] != r.observed_level) begin
         res.write_en = 1;
         res.write_level = nxt[15:0];
      end
      res.target_level = tgt[15:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_results.push_back(next_brightness(r));
            req_tdata <= 48'(r);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 31);
         if (rsp_tvalid && rsp_tready) begin
            result_type got;
            result_type want;
            got = rsp_tdata[33:0];
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               override_count += want.override_on;
               write_count += want.write_en;
               if (got.write_en != want.write_en)
                  report_mismatch("write_en", got.write_en, want.write_en);
               if (got.write_level != want.write_level)
                  report_mismatch("write_level", got.write_level, want.write_level);
               if (got.override_on != want.override_on)
                  report_mismatch("override_on", got.override_on, want.override_on);
               if (got.target_level != want.target_level)
                  report_mismatch("target_level", got.target_level, want.target_level);
            end
         end
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_CURVE: sel_curve = value[0];
         REG_MAX:   full_scale = value[15:0];
         REG_FLOOR: floor_limit = value[6:0];
         REG_RPCT:  resume_rel = value[9:0];
         REG_RABS:  resume_min = value[15:0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (pending_requests.size() > 0 || expected_results.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic request_type tracking_request();
      request_type r;
      r.lux = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(1200));
      r.observed_valid = ($urandom_range(15) != 0);
      r.boost = ($urandom_range(3) == 0) ? 7'($urandom_range(100)) : 7'd0;
      if ($urandom_range(9) == 0 || !held_valid) r.observed_level = 16'($urandom);
      else r.observed_level = held_level;
      return r;
   endfunction

   initial begin
      request_type r;
      int unsigned settings[5][5];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 0;
      sel_curve = 0; full_scale = 255; floor_limit = 2; resume_rel = 75; resume_min = 5;
      held_level = 0; held_valid = 0; yielding = 0; base_lux = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: failed read first, then curve ends, override start and release.
      pending_requests.push_back('{7'd0, 1'b0, 16'hFFFF, 20'hFFFFF});
      pending_requests.push_back('{7'd0, 1'b1, 16'd0, 20'd0});
      pending_requests.push_back('{7'd100, 1'b1, 16'd17, 20'd1000});
      pending_requests.push_back('{7'd0, 1'b1, 16'd999, 20'd100});
      pending_requests.push_back('{7'd0, 1'b0, 16'd5, 20'd100});
      pending_requests.push_back('{7'd0, 1'b1, 16'd999, 20'd102});
      pending_requests.push_back('{7'd0, 1'b1, 16'd999, 20'd300});
      pending_requests.push_back('{7'd127, 1'b1, 16'hFFFF, 20'hFFFFF});
      pending_requests.push_back('{7'd50, 1'b1, 16'd0, 20'd7});
      drain_results();

      settings = '{'{1, 65535, 100, 1000, 65535}, '{0, 1, 0, 0, 0},
                   '{1, 0, 127, 0, 0}, '{0, 1000, 0, 1023, 1},
                   '{0, 255, 2, 75, 5}};
      for (int phase = 0; phase < 5; phase++) begin
         for (int i = 0; i < 5; i++) write_register(3'(i), settings[phase][i]);
         pending_requests.push_back('{7'd0, 1'b1, 16'd0, 20'd0});
         pending_requests.push_back('{7'd0, 1'b1, 16'd300, 20'd30});
         pending_requests.push_back('{7'd0, 1'b1, 16'd300, 20'd30});
         calm = (phase == 2);
         for (int n = 0; n < 240; n++) begin
            while (pending_requests.size() > 2) @(posedge clock);
            r = tracking_request();
            pending_requests.push_back(r);
         end
         drain_results();
      end

      $display("Checked %0d results over 6 register settings: %0d level writes, %0d override ticks.",
               result_count, write_count, override_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/abc_pkg.sv
hdl/abc_divider.sv
hdl/ambient_brightness_channel_top.sv
verif/tb_ambient_brightness_channel_top.sv
